[src/nfc_response_frame_parser_assert.svh]
// Assertion macros used by the checker of the frame parser.
`ifndef NFC_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define NFC_RESPONSE_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NFCRFP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NFCRFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/nfcrfp_pkg.sv]
`default_nettype none
package nfcrfp_pkg;

   localparam int MAX_FRAME_LEN_DEFAULT = 64;
   localparam logic [7:0] FRAME_LEN_MIN = 8'd2;
   localparam logic [7:0] CAPACITY_RESET = 8'd64;

   localparam logic [7:0] START_CODE1 = 8'h00;
   localparam logic [7:0] START_CODE2 = 8'hFF;
   localparam logic [7:0] PREAMBLE = 8'h00;
   localparam logic [7:0] TFI_TO_HOST = 8'hD5;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_NOT_READY = 3'd1;
   localparam logic [2:0] STATUS_BAD_START = 3'd2;
   localparam logic [2:0] STATUS_LEN_CHECKSUM = 3'd3;
   localparam logic [2:0] STATUS_BAD_LEN = 3'd4;
   localparam logic [2:0] STATUS_BAD_TFI = 3'd5;
   localparam logic [2:0] STATUS_DATA_CHECKSUM = 3'd6;
   localparam logic [2:0] STATUS_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_of_read;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic [2:0] status_code;
      logic [7:0] delivered_count;
   } rsp_type;

endpackage
`default_nettype wire

[src/nfc_response_frame_parser.sv]
// Response frame parser for an NFC controller read. Takes one byte per cycle;
// each accepted byte updates the frame state in the same cycle and, when it
// yields a data byte or a final status, loads the result register, so a result
// appears in the cycle after its byte is accepted. req_ready is low only while
// the result register holds an item that is not being taken. A byte flagged
// first_of_read always restarts parsing. After a status, bytes are ignored
// until the next flagged byte. out_capacity may be written only while idle.
`default_nettype none
module nfc_response_frame_parser #(
   parameter int MAX_FRAME_LEN = nfcrfp_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  nfcrfp_pkg::req_type  req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output nfcrfp_pkg::rsp_type  rsp_payload,
   input  wire                  csr_write_enable,
   input  wire  [7:0]           csr_write_data
);

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_PRE  = 4'd1;
   localparam logic [3:0] PH_S1   = 4'd2;
   localparam logic [3:0] PH_S2   = 4'd3;
   localparam logic [3:0] PH_LEN  = 4'd4;
   localparam logic [3:0] PH_LCS  = 4'd5;
   localparam logic [3:0] PH_TFI  = 4'd6;
   localparam logic [3:0] PH_DATA = 4'd7;
   localparam logic [3:0] PH_DCS  = 4'd8;

   localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME_LEN);

   logic [7:0] capacity_ff, capacity_in;
   logic [3:0] phase_ff, phase_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] sent_count_ff, sent_count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   nfcrfp_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic       accept;
   logic       emit;
   logic       emit_status;
   logic [2:0] code;
   logic [7:0] b;
   logic [7:0] sum_next;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign b           = req_payload.rx_byte;
   assign sum_next    = running_sum_ff + b;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      sent_count_in   = sent_count_ff;
      emit            = 1'b0;
      emit_status     = 1'b0;
      code            = nfcrfp_pkg::STATUS_OK;
      if (req_payload.first_of_read) begin
         frame_length_in = 8'd0;
         bytes_left_in   = 8'd0;
         running_sum_in  = 8'd0;
         sent_count_in   = 8'd0;
         if (!b[0]) begin
            emit_status = 1'b1;
            code        = nfcrfp_pkg::STATUS_NOT_READY;
         end else begin
            phase_in = PH_PRE;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_PRE: begin
               if (b != nfcrfp_pkg::PREAMBLE) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_BAD_START;
               end else begin
                  phase_in = PH_S1;
               end
            end
            PH_S1: begin
               if (b != nfcrfp_pkg::START_CODE1) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_BAD_START;
               end else begin
                  phase_in = PH_S2;
               end
            end
            PH_S2: begin
               if (b != nfcrfp_pkg::START_CODE2) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_BAD_START;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               frame_length_in = b;
               phase_in        = PH_LCS;
            end
            PH_LCS: begin
               if (8'(frame_length_ff + b) != 8'd0) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_LEN_CHECKSUM;
               end else if (frame_length_ff < nfcrfp_pkg::FRAME_LEN_MIN ||
                            frame_length_ff > LEN_MAX) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_BAD_LEN;
               end else begin
                  phase_in = PH_TFI;
               end
            end
            PH_TFI: begin
               if (b != nfcrfp_pkg::TFI_TO_HOST) begin
                  emit_status = 1'b1;
                  code        = nfcrfp_pkg::STATUS_BAD_TFI;
               end else begin
                  running_sum_in = nfcrfp_pkg::TFI_TO_HOST;
                  bytes_left_in  = frame_length_ff - 8'd1;
                  phase_in       = PH_DATA;
               end
            end
            PH_DATA: begin
               running_sum_in = sum_next;
               bytes_left_in  = bytes_left_ff - 8'd1;
               if (bytes_left_ff == 8'd1) begin
                  phase_in = PH_DCS;
               end
               if (sent_count_ff < capacity_ff) begin
                  sent_count_in = sent_count_ff + 8'd1;
                  emit          = 1'b1;
               end
            end
            PH_DCS: begin
               running_sum_in = sum_next;
               emit_status    = 1'b1;
               code           = (sum_next == 8'd0) ? nfcrfp_pkg::STATUS_OK
                                                   : nfcrfp_pkg::STATUS_DATA_CHECKSUM;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (emit_status) begin
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (accept && (emit || emit_status)) begin
         rsp_valid_in = 1'b1;
         if (emit_status) begin
            rsp_payload_in.out_byte        = 8'd0;
            rsp_payload_in.is_status       = 1'b1;
            rsp_payload_in.status_code     = code;
            rsp_payload_in.delivered_count = sent_count_in;
         end else begin
            rsp_payload_in.out_byte        = b;
            rsp_payload_in.is_status       = 1'b0;
            rsp_payload_in.status_code     = nfcrfp_pkg::STATUS_OK;
            rsp_payload_in.delivered_count = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         capacity_ff     <= nfcrfp_pkg::CAPACITY_RESET;
         phase_ff        <= PH_IDLE;
         frame_length_ff <= 8'd0;
         bytes_left_ff   <= 8'd0;
         running_sum_ff  <= 8'd0;
         sent_count_ff   <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            frame_length_ff <= frame_length_in;
            bytes_left_ff   <= bytes_left_in;
            running_sum_ff  <= running_sum_in;
            sent_count_ff   <= sent_count_in;
         end
      end
   end

endmodule
`default_nettype wire

[src/nfcrfp_checker.sv]
`default_nettype none
`include "nfc_response_frame_parser_assert.svh"
module nfcrfp_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input nfcrfp_pkg::req_type req_payload,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input nfcrfp_pkg::rsp_type rsp_payload
);

   `NFCRFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result item changed while stalled")
   `NFCRFP_ASSERT_SAME(a_data_clean, rsp_valid && !rsp_payload.is_status, rsp_payload.status_code == nfcrfp_pkg::STATUS_OK && rsp_payload.delivered_count == 8'd0, "data item carries status fields")
   `NFCRFP_ASSERT_NEXT(a_not_ready, req_valid && req_ready && req_payload.first_of_read && !req_payload.rx_byte[0], rsp_valid && rsp_payload.is_status && rsp_payload.status_code == nfcrfp_pkg::STATUS_NOT_READY && rsp_payload.delivered_count == 8'd0, "not ready byte gave no status")
   `NFCRFP_ASSERT_SAME(a_code_range, rsp_valid, rsp_payload.status_code != nfcrfp_pkg::STATUS_UNUSED, "unused status code")

endmodule

bind nfc_response_frame_parser nfcrfp_checker u_nfcrfp_checker (.*);
`default_nettype wire

[bench/nfc_response_frame_parser_test.sv]
`default_nettype none
module nfc_response_frame_parser_test;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT = 5000;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PREAMBLE = 4'd1;
   localparam logic [3:0] ST_START1   = 4'd2;
   localparam logic [3:0] ST_START2   = 4'd3;
   localparam logic [3:0] ST_LEN      = 4'd4;
   localparam logic [3:0] ST_LCS      = 4'd5;
   localparam logic [3:0] ST_TFI      = 4'd6;
   localparam logic [3:0] ST_DATA     = 4'd7;
   localparam logic [3:0] ST_DCS      = 4'd8;

   typedef enum logic [1:0] {
      SINK_ALWAYS, SINK_HALF, SINK_SPARSE, SINK_PATTERN
   } sink_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   nfcrfp_pkg::req_type req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   nfcrfp_pkg::rsp_type rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [7:0]          csr_write_data = 8'h00;

   logic [3:0]   p_state = ST_IDLE;
   logic [7:0]   p_length = 8'h00;
   logic [7:0]   p_left = 8'h00;
   logic [7:0]   p_sum = 8'h00;
   logic [7:0]   p_sent = 8'h00;
   logic [7:0]   out_capacity = nfcrfp_pkg::CAPACITY_RESET;

   nfcrfp_pkg::rsp_type awaited_frame_out[$];

   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int data_checked = 0;
   int status_checked[8];

   sink_mode_type sink_mode = SINK_ALWAYS;
   logic [7:0] sink_left = 8'h00;

   nfc_response_frame_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic nfcrfp_pkg::rsp_type frame_status(input logic [2:0] code);
      nfcrfp_pkg::rsp_type st;
      st = '0;
      st.is_status = 1'b1;
      st.status_code = code;
      st.delivered_count = p_sent;
      p_state = ST_IDLE;
      return st;
   endfunction

   function automatic void parse_rx_byte(input nfcrfp_pkg::req_type item);
      nfcrfp_pkg::rsp_type out;
      logic                emit;
      logic [7:0]          lcs_sum;
      out = '0;
      emit = 1'b0;
      lcs_sum = p_length + item.rx_byte;
      if (item.first_of_read) begin
         p_length = 8'h00;
         p_left = 8'h00;
         p_sum = 8'h00;
         p_sent = 8'h00;
         if (!item.rx_byte[0]) begin
            out = frame_status(nfcrfp_pkg::STATUS_NOT_READY);
            emit = 1'b1;
         end else begin
            p_state = ST_PREAMBLE;
         end
      end else begin
         case (p_state)
            ST_PREAMBLE: begin
               if (item.rx_byte != nfcrfp_pkg::PREAMBLE) begin
                  out = frame_status(nfcrfp_pkg::STATUS_BAD_START);
                  emit = 1'b1;
               end else begin
                  p_state = ST_START1;
               end
            end
            ST_START1: begin
               if (item.rx_byte != nfcrfp_pkg::START_CODE1) begin
                  out = frame_status(nfcrfp_pkg::STATUS_BAD_START);
                  emit = 1'b1;
               end else begin
                  p_state = ST_START2;
               end
            end
            ST_START2: begin
               if (item.rx_byte != nfcrfp_pkg::START_CODE2) begin
                  out = frame_status(nfcrfp_pkg::STATUS_BAD_START);
                  emit = 1'b1;
               end else begin
                  p_state = ST_LEN;
               end
            end
            ST_LEN: begin
               p_length = item.rx_byte;
               p_state = ST_LCS;
            end
            ST_LCS: begin
               if (lcs_sum != 8'h00) begin
                  out = frame_status(nfcrfp_pkg::STATUS_LEN_CHECKSUM);
                  emit = 1'b1;
               end else if (p_length < nfcrfp_pkg::FRAME_LEN_MIN ||
                            p_length > nfcrfp_pkg::MAX_FRAME_LEN_DEFAULT) begin
                  out = frame_status(nfcrfp_pkg::STATUS_BAD_LEN);
                  emit = 1'b1;
               end else begin
                  p_state = ST_TFI;
               end
            end
            ST_TFI: begin
               if (item.rx_byte != nfcrfp_pkg::TFI_TO_HOST) begin
                  out = frame_status(nfcrfp_pkg::STATUS_BAD_TFI);
                  emit = 1'b1;
               end else begin
                  p_sum = nfcrfp_pkg::TFI_TO_HOST;
                  p_left = p_length - 8'd1;
                  p_state = ST_DATA;
               end
            end
            ST_DATA: begin
               p_sum = p_sum + item.rx_byte;
               p_left = p_left - 8'd1;
               if (p_left == 8'h00) begin
                  p_state = ST_DCS;
               end
               if (p_sent < out_capacity) begin
                  p_sent = p_sent + 8'd1;
                  out.out_byte = item.rx_byte;
                  emit = 1'b1;
               end
            end
            ST_DCS: begin
               p_sum = p_sum + item.rx_byte;
               out = frame_status(p_sum == 8'h00 ? nfcrfp_pkg::STATUS_OK
                                                 : nfcrfp_pkg::STATUS_DATA_CHECKSUM);
               emit = 1'b1;
            end
            default: begin
               p_state = ST_IDLE;
            end
         endcase
      end
      if (emit) begin
         awaited_frame_out.push_back(out);
      end
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_frame_out(input nfcrfp_pkg::rsp_type got);
      nfcrfp_pkg::rsp_type want;
      if (awaited_frame_out.size() == 0) begin
         report_error($sformatf("result %h arrived with nothing expected", got));
      end else begin
         want = awaited_frame_out.pop_front();
         if (got.out_byte != want.out_byte)
            report_error($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
         if (got.is_status != want.is_status)
            report_error($sformatf("is_status %b, expected %b", got.is_status, want.is_status));
         if (got.status_code != want.status_code)
            report_error($sformatf("status_code %0d, expected %0d",
                                   got.status_code, want.status_code));
         if (got.delivered_count != want.delivered_count)
            report_error($sformatf("delivered_count %0d, expected %0d",
                                   got.delivered_count, want.delivered_count));
         if (want.is_status) begin
            status_checked[want.status_code]++;
         end else begin
            data_checked++;
         end
      end
   endtask

   // check results before taking in the byte accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_frame_out(rsp_payload);
         end
         if (req_valid && req_ready) begin
            parse_rx_byte(req_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("nfc_response_frame_parser test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (sink_left == 8'h00) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= 8'($urandom_range(20, 200));
      end else begin
         sink_left <= sink_left - 8'd1;
      end
      case (sink_mode)
         SINK_ALWAYS: rsp_ready <= 1'b1;
         SINK_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
         default:     rsp_ready <= (sink_left[2:0] > 3'd2);
      endcase
   end

   task automatic send_item(input logic [7:0] value, input logic first);
      nfcrfp_pkg::req_type item;
      int                  gap;
      item.rx_byte = value;
      item.first_of_read = first;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_frame_bytes(input logic [7:0] frame[$]);
      for (int i = 0; i < frame.size(); i++) begin
         send_item(frame[i], i == 0);
      end
   endtask

   // hold the sender until every awaited result is out
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (awaited_frame_out.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [7:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      out_capacity = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_frame();
      logic [7:0] frame[$];
      logic [7:0] len_byte;
      logic [7:0] data_sum;
      logic [7:0] delta;
      logic [7:0] d;
      int         pick;
      int         kind;
      int         len;
      int         cut;
      int         pos;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         len = $urandom_range(0, 1) ? nfcrfp_pkg::MAX_FRAME_LEN_DEFAULT : 2;
      end else if (pick < 30) begin
         len = $urandom_range(11, nfcrfp_pkg::MAX_FRAME_LEN_DEFAULT - 1);
      end else begin
         len = $urandom_range(2, 10);
      end
      len_byte = 8'(len);
      frame = {8'($urandom_range(0, 255)) | 8'h01, nfcrfp_pkg::PREAMBLE,
               nfcrfp_pkg::START_CODE1, nfcrfp_pkg::START_CODE2,
               len_byte, 8'h00 - len_byte, nfcrfp_pkg::TFI_TO_HOST};
      data_sum = nfcrfp_pkg::TFI_TO_HOST;
      for (int i = 1; i < len; i++) begin
         d = 8'($urandom_range(0, 255));
         frame.push_back(d);
         data_sum = data_sum + d;
      end
      frame.push_back(8'h00 - data_sum);
      cut = frame.size();
      delta = 8'($urandom_range(1, 255));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
      end else if (kind < 60) begin
         frame[0][0] = 1'b0;
         cut = 1;
      end else if (kind < 66) begin
         pos = $urandom_range(1, 3);
         frame[pos] = frame[pos] ^ delta;
         cut = pos + 1;
      end else if (kind < 72) begin
         frame[4] = 8'($urandom_range(0, 255));
         frame[5] = 8'h00 - frame[4] + delta;
         cut = 6;
      end else if (kind < 78) begin
         case ($urandom_range(0, 2))
            0: frame[4] = 8'h00;
            1: frame[4] = 8'h01;
            default: frame[4] = 8'($urandom_range(nfcrfp_pkg::MAX_FRAME_LEN_DEFAULT + 1, 255));
         endcase
         frame[5] = 8'h00 - frame[4];
         cut = 6;
      end else if (kind < 84) begin
         frame[6] = frame[6] ^ delta;
         cut = 7;
      end else if (kind < 92) begin
         frame[frame.size() - 1] = frame[frame.size() - 1] ^ delta;
      end else if (kind < 97) begin
         cut = $urandom_range(1, frame.size() - 1);
      end else begin
         repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)),
                                                 $urandom_range(0, 3) == 0);
         return;
      end
      while (frame.size() > cut) frame.pop_back();
      send_frame_bytes(frame);
      repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic run_random_frames(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) begin
         send_random_frame();
         if ($urandom_range(0, 24) == 0) begin
            wait_idle();
         end
      end
   endtask

   task automatic test_directed_frames();
      logic [7:0] frame[$];
      send_item(8'hFF, 1'b0);
      send_item(8'hFE, 1'b1);
      frame = {8'h01, 8'h80};
      send_frame_bytes(frame);
      // drop a partial frame by opening a new read
      frame = {8'hFF, nfcrfp_pkg::PREAMBLE, nfcrfp_pkg::START_CODE1};
      send_frame_bytes(frame);
      frame = {8'h01, nfcrfp_pkg::PREAMBLE, nfcrfp_pkg::START_CODE1, nfcrfp_pkg::START_CODE2,
               8'h02, 8'hFE, nfcrfp_pkg::TFI_TO_HOST, 8'hFF, 8'h2C};
      send_frame_bytes(frame);
      send_item(8'h00, 1'b0);
      frame = {8'h81, nfcrfp_pkg::PREAMBLE, nfcrfp_pkg::START_CODE1, nfcrfp_pkg::START_CODE2,
               8'h41, 8'hBF};
      send_frame_bytes(frame);
      wait_idle();
   endtask

   task automatic test_reset_capacity();
      run_random_frames(340);
   endtask

   task automatic test_zero_capacity();
      write_capacity(8'h00);
      run_random_frames(300);
   endtask

   task automatic test_single_capacity();
      write_capacity(8'h01);
      run_random_frames(300);
   endtask

   task automatic test_full_capacity();
      write_capacity(8'hFF);
      run_random_frames(360);
   endtask

   task automatic test_varied_capacity();
      repeat (6) begin
         write_capacity(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 8))
                                                     : 8'($urandom_range(0, 255)));
         run_random_frames(65);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_reset_capacity();
      test_zero_capacity();
      test_single_capacity();
      test_full_capacity();
      test_varied_capacity();
      wait_idle();
      $display("sent %0d bytes over capacities 0, 1, 64, 255 and random; checked %0d data bytes",
               items_sent, data_checked);
      $display("statuses ok %0d, not ready %0d, start %0d, lcs %0d, len %0d, tfi %0d, dcs %0d",
               status_checked[nfcrfp_pkg::STATUS_OK],
               status_checked[nfcrfp_pkg::STATUS_NOT_READY],
               status_checked[nfcrfp_pkg::STATUS_BAD_START],
               status_checked[nfcrfp_pkg::STATUS_LEN_CHECKSUM],
               status_checked[nfcrfp_pkg::STATUS_BAD_LEN],
               status_checked[nfcrfp_pkg::STATUS_BAD_TFI],
               status_checked[nfcrfp_pkg::STATUS_DATA_CHECKSUM]);
      if (errors == 0) begin
         $display("nfc_response_frame_parser test passed");
      end else begin
         $display("nfc_response_frame_parser test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
